// ===== sv/first_fit_free_list_allocator_macros.svh =====
// Assertion helpers for the allocator. Both expect signals named clock and reset in scope.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define FFA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FFA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ffa_pkg.sv =====
`default_nettype none
package ffa_pkg;

   localparam int unsigned ArenaBytes = 4096;
   localparam int unsigned HdrBytes   = 16;
   localparam int unsigned OffW       = 12;
   localparam int unsigned ArenaAw    = $clog2(ArenaBytes);

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_NOMEM   = 2'd1,
      ST_BADFREE = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [OffW-1:0]   req_size;
      logic [OffW-1:0]   free_offset;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [OffW-1:0]   payload_offset;
   } rsp_type;

   // One block header: payload size, next free block, next valid, allocated mark.
   typedef struct packed {
      logic [OffW-1:0]    size;
      logic [ArenaAw-1:0] next;
      logic               has_next;
      logic               alloc;
   } hdr_type;

   localparam int unsigned HdrW = $bits(hdr_type);

   typedef struct packed {
      logic               en;
      logic [ArenaAw-1:0] addr;
      hdr_type            data;
   } wr_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_A_WALK,
      S_F_CHK,
      S_F_WALK,
      S_WRITE,
      S_C_START,
      S_C_HEAD,
      S_C_NEXT,
      S_RESP
   } state_type;

endpackage
`default_nettype wire

// ===== sv/ffa_ram.sv =====
`default_nettype none
module ffa_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== sv/first_fit_free_list_allocator.sv =====
`default_nettype none
// Channel  Direction  Word      Handshake
// req      in         req_type  req_valid / req_ready
// rsp      out        rsp_type  rsp_valid / rsp_ready
//
// After reset the header memory is swept once, one entry per cycle, through every entry, while
// req_ready stays low. An allocate reads the free-list head and walks the list node by node,
// then drains one to three header writes and loads the result register. A free adds
// a lookup and walk in the same way, then a coalescing pass that visits every free
// node. These steps go one at a time through the single read and single write port
// of the header memory. A new word is taken only in idle; the result register lets
// the block return to idle while an earlier result waits for rsp_ready.
module first_fit_free_list_allocator (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire ffa_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output ffa_pkg::rsp_type     rsp_data
);
   import ffa_pkg::*;

`include "first_fit_free_list_allocator_macros.svh"

   localparam logic [OffW-1:0] InitSize = OffW'(ArenaBytes - HdrBytes);

   state_type          state_ff, state_in;
   logic [ArenaAw-1:0] clr_cnt_ff, clr_cnt_in;
   logic [ArenaAw-1:0] head_ff, head_in;
   logic               head_vld_ff, head_vld_in;
   logic [ArenaAw-1:0] cur_ff, cur_in;
   logic [ArenaAw-1:0] pre_ff, pre_in;
   logic [ArenaAw-1:0] blk_ff, blk_in;
   hdr_type            pre_hdr_ff, pre_hdr_in;
   hdr_type            blk_hdr_ff, blk_hdr_in;
   req_type            req_ff, req_in;
   wr_type             wq_ff [3];
   wr_type             wq_in [3];
   logic               coal_ff, coal_in;
   logic               dirty_ff, dirty_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               ram_we;
   logic [ArenaAw-1:0] ram_waddr;
   hdr_type            ram_wdata;
   logic               ram_re;
   logic [ArenaAw-1:0] ram_raddr;
   logic [HdrW-1:0]    ram_rdata;

   ffa_ram #(
      .Width (HdrW),
      .Depth (ArenaBytes)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         head_ff      <= '0;
         head_vld_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
         coal_ff      <= 1'b0;
         dirty_ff     <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            wq_ff[i].en <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         head_ff      <= head_in;
         head_vld_ff  <= head_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         coal_ff      <= coal_in;
         dirty_ff     <= dirty_in;
         for (int i = 0; i < 3; i++) begin
            wq_ff[i].en <= wq_in[i].en;
         end
      end
      cur_ff      <= cur_in;
      pre_ff      <= pre_in;
      blk_ff      <= blk_in;
      pre_hdr_ff  <= pre_hdr_in;
      blk_hdr_ff  <= blk_hdr_in;
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < 3; i++) begin
         wq_ff[i].addr <= wq_in[i].addr;
         wq_ff[i].data <= wq_in[i].data;
      end
   end

   always_comb begin
      hdr_type            h;
      hdr_type            t;
      logic [13:0]        nb;
      logic [13:0]        pre_end;
      logic [ArenaAw-1:0] fblk;

      h          = hdr_type'(ram_rdata);
      t          = h;
      nb         = 14'(cur_ff) + 14'(HdrBytes) + 14'(req_ff.req_size);
      pre_end    = 14'(pre_ff) + 14'(HdrBytes) + 14'(pre_hdr_ff.size);
      fblk       = req_data.free_offset - ArenaAw'(HdrBytes);

      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      head_in     = head_ff;
      head_vld_in = head_vld_ff;
      cur_in      = cur_ff;
      pre_in      = pre_ff;
      blk_in      = blk_ff;
      pre_hdr_in  = pre_hdr_ff;
      blk_hdr_in  = blk_hdr_ff;
      req_in      = req_ff;
      coal_in     = coal_ff;
      dirty_in    = dirty_ff;
      res_in      = res_ff;
      wq_in       = wq_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      req_ready = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = '0;

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_ff;
            if (clr_cnt_ff == '0) begin
               ram_wdata.size = InitSize;
            end
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == '1) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_data;
               res_in = '{status: ST_DONE, payload_offset: '0};
               if (req_data.cmd == CMD_ALLOC) begin
                  if (req_data.req_size == '0) begin
                     state_in = S_RESP;
                  end else if (!head_vld_ff) begin
                     res_in.status = ST_NOMEM;
                     state_in      = S_RESP;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = head_ff;
                     cur_in    = head_ff;
                     pre_in    = head_ff;
                     state_in  = S_A_WALK;
                  end
               end else begin
                  if (req_data.free_offset == '0) begin
                     state_in = S_RESP;
                  end else if (req_data.free_offset < OffW'(HdrBytes)) begin
                     res_in.status = ST_BADFREE;
                     state_in      = S_RESP;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = fblk;
                     blk_in    = fblk;
                     state_in  = S_F_CHK;
                  end
               end
            end
         end

         // Walk while the block is too small and another one follows.
         S_A_WALK: begin
            if ((h.size < req_ff.req_size) && h.has_next) begin
               pre_in     = cur_ff;
               pre_hdr_in = h;
               cur_in     = h.next;
               ram_re     = 1'b1;
               ram_raddr  = h.next;
            end else if (h.size == req_ff.req_size) begin
               if (cur_ff == head_ff) begin
                  head_vld_in = h.has_next;
                  head_in     = h.has_next ? h.next : '0;
               end else begin
                  t          = pre_hdr_ff;
                  t.next     = h.next;
                  t.has_next = h.has_next;
                  wq_in[1]   = '{en: 1'b1, addr: pre_ff, data: t};
               end
               t          = h;
               t.alloc    = 1'b1;
               t.has_next = 1'b0;
               t.next     = '0;
               wq_in[0]   = '{en: 1'b1, addr: cur_ff, data: t};
               res_in.payload_offset = cur_ff + OffW'(HdrBytes);
               coal_in  = 1'b0;
               state_in = S_WRITE;
            end else if ({1'b0, h.size} >= ({1'b0, req_ff.req_size} + 13'(HdrBytes))) begin
               if (nb >= 14'(ArenaBytes)) begin
                  res_in.status = ST_NOMEM;
                  state_in      = S_RESP;
               end else begin
                  // Split: the surplus becomes a new free block right after the grant.
                  t.size     = h.size - req_ff.req_size - OffW'(HdrBytes);
                  t.next     = h.next;
                  t.has_next = h.has_next;
                  t.alloc    = 1'b0;
                  wq_in[1]   = '{en: 1'b1, addr: nb[ArenaAw-1:0], data: t};
                  if (cur_ff == head_ff) begin
                     head_in = nb[ArenaAw-1:0];
                  end else begin
                     t          = pre_hdr_ff;
                     t.next     = nb[ArenaAw-1:0];
                     t.has_next = 1'b1;
                     wq_in[2]   = '{en: 1'b1, addr: pre_ff, data: t};
                  end
                  t          = '0;
                  t.size     = req_ff.req_size;
                  t.alloc    = 1'b1;
                  wq_in[0]   = '{en: 1'b1, addr: cur_ff, data: t};
                  res_in.payload_offset = cur_ff + OffW'(HdrBytes);
                  coal_in  = 1'b0;
                  state_in = S_WRITE;
               end
            end else begin
               res_in.status = ST_NOMEM;
               state_in      = S_RESP;
            end
         end

         S_F_CHK: begin
            t       = h;
            t.alloc = 1'b0;
            if (!h.alloc) begin
               res_in.status = ST_BADFREE;
               state_in      = S_RESP;
            end else if (!head_vld_ff) begin
               t.has_next  = 1'b0;
               t.next      = '0;
               head_in     = blk_ff;
               head_vld_in = 1'b1;
               wq_in[0]    = '{en: 1'b1, addr: blk_ff, data: t};
               coal_in     = 1'b1;
               state_in    = S_WRITE;
            end else if (blk_ff < head_ff) begin
               t.next     = head_ff;
               t.has_next = 1'b1;
               head_in    = blk_ff;
               wq_in[0]   = '{en: 1'b1, addr: blk_ff, data: t};
               coal_in    = 1'b1;
               state_in   = S_WRITE;
            end else begin
               blk_hdr_in = t;
               cur_in     = head_ff;
               ram_re     = 1'b1;
               ram_raddr  = head_ff;
               state_in   = S_F_WALK;
            end
         end

         // Find the last free block at or below the released one.
         S_F_WALK: begin
            if (h.has_next && !(blk_ff < h.next)) begin
               cur_in    = h.next;
               ram_re    = 1'b1;
               ram_raddr = h.next;
            end else begin
               t          = blk_hdr_ff;
               t.next     = h.next;
               t.has_next = h.has_next;
               wq_in[0]   = '{en: 1'b1, addr: blk_ff, data: t};
               t          = h;
               t.next     = blk_ff;
               t.has_next = 1'b1;
               wq_in[1]   = '{en: 1'b1, addr: cur_ff, data: t};
               coal_in    = 1'b1;
               state_in   = S_WRITE;
            end
         end

         // Drain the pending header writes, lowest slot first.
         S_WRITE: begin
            ram_we = 1'b1;
            if (wq_ff[0].en) begin
               ram_waddr   = wq_ff[0].addr;
               ram_wdata   = wq_ff[0].data;
               wq_in[0].en = 1'b0;
            end else if (wq_ff[1].en) begin
               ram_waddr   = wq_ff[1].addr;
               ram_wdata   = wq_ff[1].data;
               wq_in[1].en = 1'b0;
            end else begin
               ram_waddr   = wq_ff[2].addr;
               ram_wdata   = wq_ff[2].data;
               wq_in[2].en = 1'b0;
            end
            if (!wq_in[0].en && !wq_in[1].en && !wq_in[2].en) begin
               state_in = coal_ff ? S_C_START : S_RESP;
            end
         end

         S_C_START: begin
            ram_re    = 1'b1;
            ram_raddr = head_ff;
            pre_in    = head_ff;
            state_in  = S_C_HEAD;
         end

         S_C_HEAD: begin
            pre_hdr_in = h;
            dirty_in   = 1'b0;
            if (h.has_next) begin
               ram_re    = 1'b1;
               ram_raddr = h.next;
               state_in  = S_C_NEXT;
            end else begin
               state_in = S_RESP;
            end
         end

         // h is the block after pre; merge it when they touch.
         S_C_NEXT: begin
            if (pre_end == 14'(pre_hdr_ff.next)) begin
               t          = pre_hdr_ff;
               t.size     = pre_hdr_ff.size + OffW'(HdrBytes) + h.size;
               t.next     = h.next;
               t.has_next = h.has_next;
               pre_hdr_in = t;
               dirty_in   = 1'b1;
               if (h.has_next) begin
                  ram_re    = 1'b1;
                  ram_raddr = h.next;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = pre_ff;
                  ram_wdata = t;
                  state_in  = S_RESP;
               end
            end else begin
               if (dirty_ff) begin
                  ram_we    = 1'b1;
                  ram_waddr = pre_ff;
                  ram_wdata = pre_hdr_ff;
               end
               pre_in     = pre_hdr_ff.next;
               pre_hdr_in = h;
               dirty_in   = 1'b0;
               if (h.has_next) begin
                  ram_re    = 1'b1;
                  ram_raddr = h.next;
               end else begin
                  state_in = S_RESP;
               end
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The header memory is written only by the sweep, the write drain and the merge step.
   `FFA_ASSERT_IMP(a_write_states, ram_we, (state_ff == S_CLEAR) || (state_ff == S_WRITE) || (state_ff == S_C_NEXT), "header write outside a writing state")
   // A taken word always leaves idle.
   `FFA_ASSERT_NXT(a_accept_busy, req_valid && req_ready, state_ff != S_IDLE, "accepted word left block idle")
   // Loading the result register returns to idle with a valid word.
   `FFA_ASSERT_NXT(a_result_load, (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (state_ff == S_IDLE), "result not loaded")

endmodule
`default_nettype wire
